[rtl/core/bsnm_pkg.sv]
// Shared constants, types and helpers for the nearest-member bitmap set.
// Used by bsnm_scan and the top level under rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bsnm_pkg;

    // Covered value range is 0 .. 2^VALUE_BITS - 1
    localparam int VALUE_BITS   = 12;
    localparam int WORD_BITS    = 32;
    localparam int BIT_IDX_W    = $clog2(WORD_BITS);
    localparam int TOTAL_VALUES = 1 << VALUE_BITS;
    localparam int NUM_WORDS    = TOTAL_VALUES / WORD_BITS;
    localparam int WORD_IDX_W   = VALUE_BITS - BIT_IDX_W;

    // Occupancy flags are kept in chunks that the shared search unit covers in one step
    localparam int SCAN_BITS    = (NUM_WORDS < WORD_BITS) ? NUM_WORDS : WORD_BITS;
    localparam int SCAN_IDX_W   = $clog2(SCAN_BITS);
    localparam int NUM_CHUNKS   = NUM_WORDS / SCAN_BITS;
    localparam int CHUNK_IDX_W  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_CLOSEST = 2'd1;
    localparam logic [1:0] OP_MEMBER  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [WORD_BITS-1:0] vec;
        logic                 find_high;
    } scan_req_t;

    typedef struct packed {
        logic                 found;
        logic [BIT_IDX_W-1:0] idx;
    } scan_rsp_t;

    // Flag chunk that holds a given word's occupancy bit
    function automatic logic [CHUNK_IDX_W-1:0] chunk_of(input logic [WORD_IDX_W-1:0] w);
        logic [WORD_IDX_W:0] tmp;
        tmp = {1'b0, w} >> SCAN_IDX_W;
        return tmp[CHUNK_IDX_W-1:0];
    endfunction

    // Word index from chunk index and position inside the chunk
    function automatic logic [WORD_IDX_W-1:0] word_of(input logic [CHUNK_IDX_W-1:0] c,
                                                      input logic [SCAN_IDX_W-1:0] p);
        return WORD_IDX_W'({c, p});
    endfunction

endpackage

`default_nettype wire

[rtl/core/bsnm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module bsnm_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire  logic                  clk,
    input  wire  logic                  we,
    input  wire  logic [ADDR_W-1:0]     waddr,
    input  wire  logic [WIDTH-1:0]      wdata,
    input  wire  logic                  re,
    input  wire  logic [ADDR_W-1:0]     raddr,
    output logic       [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/bsnm_scan.sv]
// Shared search unit: highest or lowest set bit of one 32-bit vector.
// Depends on bsnm_pkg for the request and response types.
`timescale 1ns / 1ps
`default_nettype none

module bsnm_scan (
    input  wire  bsnm_pkg::scan_req_t req,
    output bsnm_pkg::scan_rsp_t       rsp
);

    always_comb
    begin
        rsp.found = |req.vec;
        rsp.idx   = '0;
        if (req.find_high)
        begin
            for (int i = 0; i < bsnm_pkg::WORD_BITS; i++)
            begin
                if (req.vec[i])
                begin
                    rsp.idx = bsnm_pkg::BIT_IDX_W'(i);
                end
            end
        end
        else
        begin
            for (int i = bsnm_pkg::WORD_BITS - 1; i >= 0; i--)
            begin
                if (req.vec[i])
                begin
                    rsp.idx = bsnm_pkg::BIT_IDX_W'(i);
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/bitmap_set_nearest_member.sv]
// Top level of the nearest-member bitmap set: sequencer, bitmap and flag RAMs.
// Depends on bsnm_pkg, bsnm_ram and bsnm_scan.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------
//   request | in_valid, in_stall | opcode[1:0], value[15:0] (signed)
//   result  | out_valid,out_stall| nearest_value, is_member, status[1:0]
//
// Insert and membership requests read both RAMs and pass through S_LOOK,
// which an out-of-range value skips (as does an unused opcode); a closest
// query first searches the target's own word, then, for each neighbor not
// found there, scans occupancy-flag chunks one by one (NUM_CHUNKS chunks of
// SCAN_BITS flags) and fetches the neighbor word it finds. The single search
// unit and the one read port of each RAM set this sequence.
// After reset the flag RAM is cleared, one chunk a cycle, with in_stall high.
// A finished result waits in the output register while the next request is
// taken; the sequencer holds only while that register is full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_set_nearest_member (
    input  wire  logic                               clk,
    input  wire  logic                               rst_n,
    input  wire  logic                               in_valid,
    output logic                                     in_stall,
    input  wire  logic [1:0]                         opcode,
    input  wire  logic signed [15:0]                 value,
    output logic                                     out_valid,
    input  wire  logic                               out_stall,
    output logic       [bsnm_pkg::VALUE_BITS-1:0]    nearest_value,
    output logic                                     is_member,
    output logic       [1:0]                         status
);

    localparam int VB  = bsnm_pkg::VALUE_BITS;
    localparam int WB  = bsnm_pkg::WORD_BITS;
    localparam int BW  = bsnm_pkg::BIT_IDX_W;
    localparam int WIW = bsnm_pkg::WORD_IDX_W;
    localparam int SB  = bsnm_pkg::SCAN_BITS;
    localparam int SW  = bsnm_pkg::SCAN_IDX_W;
    localparam int CW  = bsnm_pkg::CHUNK_IDX_W;

    typedef enum logic [8:0] {
        S_CLEAR   = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_LOOK    = 9'b000000100,
        S_HI_WORD = 9'b000001000,
        S_DN_SCAN = 9'b000010000,
        S_DN_WORD = 9'b000100000,
        S_UP_SCAN = 9'b001000000,
        S_UP_WORD = 9'b010000000,
        S_FINISH  = 9'b100000000
    } state_t;

    // Control state
    state_t          state_reg, state_next;
    logic [CW-1:0]   cur_reg, cur_next;
    logic            first_reg, first_next;
    logic            out_valid_reg, out_valid_next;

    // Request payload and search results
    logic [1:0]      op_reg, op_next;
    logic [VB-1:0]   t_reg, t_next;
    logic [WB-1:0]   word_reg, word_next;
    logic            lo_found_reg, lo_found_next;
    logic            hi_found_reg, hi_found_next;
    logic [VB-1:0]   lo_reg, lo_next;
    logic [VB-1:0]   hi_reg, hi_next;
    logic [WIW-1:0]  hit_word_reg, hit_word_next;
    logic            member_reg, member_next;
    logic [1:0]      status_reg, status_next;

    // Output register
    logic [VB-1:0]   nearest_out_reg, nearest_out_next;
    logic            member_out_reg, member_out_next;
    logic [1:0]      status_out_reg, status_out_next;

    // RAM ports
    logic            mem_we, mem_re;
    logic [WIW-1:0]  mem_waddr, mem_raddr;
    logic [WB-1:0]   mem_wdata, mem_rdata;
    logic            flag_we, flag_re;
    logic [CW-1:0]   flag_waddr, flag_raddr;
    logic [SB-1:0]   flag_wdata, flag_rdata;

    bsnm_pkg::scan_req_t scan_req;
    bsnm_pkg::scan_rsp_t scan_rsp;

    // Incoming request decode: clamp negatives to zero, saturate above range
    logic [31:0]     mag_in;
    logic            in_range;
    logic [VB-1:0]   t_in;
    logic [WIW-1:0]  w_in;

    // Fields of the held target
    logic [WIW-1:0]  w_cur;
    logic [BW-1:0]   off_cur;
    logic [CW-1:0]   c_cur;
    logic [SW-1:0]   p_cur;
    logic [WB-1:0]   word_eff;
    logic [SB-1:0]   ones_chunk;
    logic [WB-1:0]   ones_word;
    logic [WIW-1:0]  scan_word;
    logic            start_up, start_dn;
    logic            load_out;
    logic [VB-1:0]   d_hi, d_lo;

    assign mag_in   = value[15] ? 32'd0 : {17'd0, value[14:0]};
    assign in_range = !value[15] && (mag_in < 32'(bsnm_pkg::TOTAL_VALUES));
    assign t_in     = (mag_in < 32'(bsnm_pkg::TOTAL_VALUES)) ? mag_in[VB-1:0] : '1;
    assign w_in     = t_in[VB-1:BW];

    assign w_cur      = t_reg[VB-1:BW];
    assign off_cur    = t_reg[BW-1:0];
    assign c_cur      = bsnm_pkg::chunk_of(w_cur);
    assign p_cur      = w_cur[SW-1:0];
    assign ones_chunk = '1;
    assign ones_word  = '1;
    // An unoccupied word reads as empty whatever the RAM holds
    assign word_eff   = flag_rdata[p_cur] ? mem_rdata : '0;
    assign scan_word  = bsnm_pkg::word_of(cur_reg, scan_rsp.idx[SW-1:0]);
    assign d_hi       = hi_reg - t_reg;
    assign d_lo       = t_reg - lo_reg;

    bsnm_ram #(
        .WIDTH (WB),
        .DEPTH (bsnm_pkg::NUM_WORDS)
    ) u_word_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bsnm_ram #(
        .WIDTH (SB),
        .DEPTH (bsnm_pkg::NUM_CHUNKS)
    ) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .re    (flag_re),
        .raddr (flag_raddr),
        .rdata (flag_rdata)
    );

    bsnm_scan u_scan (
        .req (scan_req),
        .rsp (scan_rsp)
    );

    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        first_next       = first_reg;
        op_next          = op_reg;
        t_next           = t_reg;
        word_next        = word_reg;
        lo_found_next    = lo_found_reg;
        hi_found_next    = hi_found_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        hit_word_next    = hit_word_reg;
        member_next      = member_reg;
        status_next      = status_reg;
        mem_we           = 1'b0;
        mem_waddr        = w_cur;
        mem_wdata        = word_eff | (WB'(1) << off_cur);
        mem_re           = 1'b0;
        mem_raddr        = w_cur;
        flag_we          = 1'b0;
        flag_waddr       = c_cur;
        flag_wdata       = flag_rdata | (SB'(1) << p_cur);
        flag_re          = 1'b0;
        flag_raddr       = c_cur;
        scan_req.vec       = word_reg;
        scan_req.find_high = 1'b1;
        start_up         = 1'b0;
        start_dn         = 1'b0;
        load_out         = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep the flag RAM to zero
                flag_we    = 1'b1;
                flag_waddr = cur_reg;
                flag_wdata = '0;
                if (cur_reg == CW'(bsnm_pkg::NUM_CHUNKS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + CW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = opcode;
                    t_next        = t_in;
                    lo_found_next = 1'b0;
                    hi_found_next = 1'b0;
                    member_next   = 1'b0;
                    status_next   = bsnm_pkg::ST_OK;
                    mem_raddr     = w_in;
                    flag_raddr    = bsnm_pkg::chunk_of(w_in);
                    case (opcode)
                        bsnm_pkg::OP_INSERT:
                        begin
                            if (in_range)
                            begin
                                mem_re     = 1'b1;
                                flag_re    = 1'b1;
                                state_next = S_LOOK;
                            end
                            else
                            begin
                                status_next = bsnm_pkg::ST_RANGE;
                                state_next  = S_FINISH;
                            end
                        end
                        bsnm_pkg::OP_MEMBER:
                        begin
                            if (in_range)
                            begin
                                mem_re     = 1'b1;
                                flag_re    = 1'b1;
                                state_next = S_LOOK;
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        bsnm_pkg::OP_CLOSEST:
                        begin
                            mem_re     = 1'b1;
                            flag_re    = 1'b1;
                            state_next = S_LOOK;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_LOOK:
            begin
                word_next = word_eff;
                case (op_reg)
                    bsnm_pkg::OP_INSERT:
                    begin
                        mem_we     = 1'b1;
                        flag_we    = 1'b1;
                        state_next = S_FINISH;
                    end
                    bsnm_pkg::OP_MEMBER:
                    begin
                        member_next = word_eff[off_cur];
                        state_next  = S_FINISH;
                    end
                    default:
                    begin
                        // Lower neighbor inside the target's word
                        scan_req.vec       = word_eff & (ones_word >> (BW'(WB - 1) - off_cur));
                        scan_req.find_high = 1'b1;
                        lo_found_next      = scan_rsp.found;
                        lo_next            = {w_cur, scan_rsp.idx};
                        state_next         = S_HI_WORD;
                    end
                endcase
            end

            S_HI_WORD:
            begin
                // Upper neighbor inside the target's word
                scan_req.vec       = word_reg & (ones_word << off_cur);
                scan_req.find_high = 1'b0;
                hi_found_next      = scan_rsp.found;
                hi_next            = {w_cur, scan_rsp.idx};
                if (!lo_found_reg)
                begin
                    start_dn = 1'b1;
                end
                else if (!scan_rsp.found)
                begin
                    start_up = 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_DN_SCAN:
            begin
                scan_req.vec       = WB'(first_reg ? (flag_rdata & ~(ones_chunk << p_cur))
                                                   : flag_rdata);
                scan_req.find_high = 1'b1;
                first_next         = 1'b0;
                if (scan_rsp.found)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = scan_word;
                    hit_word_next = scan_word;
                    state_next    = S_DN_WORD;
                end
                else if (cur_reg == '0)
                begin
                    if (!hi_found_reg)
                    begin
                        start_up = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    cur_next   = cur_reg - CW'(1);
                    flag_re    = 1'b1;
                    flag_raddr = cur_reg - CW'(1);
                end
            end

            S_DN_WORD:
            begin
                scan_req.vec       = mem_rdata;
                scan_req.find_high = 1'b1;
                lo_found_next      = 1'b1;
                lo_next            = {hit_word_reg, scan_rsp.idx};
                if (!hi_found_reg)
                begin
                    start_up = 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_UP_SCAN:
            begin
                scan_req.vec       = WB'(first_reg ? (flag_rdata & ((ones_chunk << p_cur) << 1))
                                                   : flag_rdata);
                scan_req.find_high = 1'b0;
                first_next         = 1'b0;
                if (scan_rsp.found)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = scan_word;
                    hit_word_next = scan_word;
                    state_next    = S_UP_WORD;
                end
                else if (cur_reg == CW'(bsnm_pkg::NUM_CHUNKS - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cur_next   = cur_reg + CW'(1);
                    flag_re    = 1'b1;
                    flag_raddr = cur_reg + CW'(1);
                end
            end

            S_UP_WORD:
            begin
                scan_req.vec       = mem_rdata;
                scan_req.find_high = 1'b0;
                hi_found_next      = 1'b1;
                hi_next            = {hit_word_reg, scan_rsp.idx};
                state_next         = S_FINISH;
            end

            S_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Start a flag scan from the target's chunk
        if (start_dn || start_up)
        begin
            flag_re    = 1'b1;
            flag_raddr = c_cur;
            cur_next   = c_cur;
            first_next = 1'b1;
            state_next = start_dn ? S_DN_SCAN : S_UP_SCAN;
        end
    end

    // Result assembly; on a tie in distance the lower member wins
    always_comb
    begin
        nearest_out_next = nearest_out_reg;
        member_out_next  = member_out_reg;
        status_out_next  = status_out_reg;
        out_valid_next   = out_valid_reg && out_stall;
        if (load_out)
        begin
            out_valid_next   = 1'b1;
            nearest_out_next = '0;
            member_out_next  = member_reg;
            status_out_next  = status_reg;
            if (op_reg == bsnm_pkg::OP_CLOSEST)
            begin
                if (!lo_found_reg && !hi_found_reg)
                begin
                    status_out_next = bsnm_pkg::ST_EMPTY;
                end
                else if (!hi_found_reg)
                begin
                    nearest_out_next = lo_reg;
                end
                else if (!lo_found_reg)
                begin
                    nearest_out_next = hi_reg;
                end
                else
                begin
                    nearest_out_next = (d_hi < d_lo) ? hi_reg : lo_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cur_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        t_reg           <= t_next;
        word_reg        <= word_next;
        lo_found_reg    <= lo_found_next;
        hi_found_reg    <= hi_found_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        hit_word_reg    <= hit_word_next;
        member_reg      <= member_next;
        status_reg      <= status_next;
        nearest_out_reg <= nearest_out_next;
        member_out_reg  <= member_out_next;
        status_out_reg  <= status_out_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign nearest_value = nearest_out_reg;
    assign is_member     = member_out_reg;
    assign status        = status_out_reg;

endmodule

`default_nettype wire
